// ===== rtl/core/tqc_pkg.sv =====
// Shared types and constants for the two-queue cache policy block.
package tqc_pkg;

   localparam int MAIN_DEPTH_DEF = 16;
   localparam int IN_DEPTH_DEF   = 8;
   localparam int OUT_DEPTH_DEF  = 8;

   localparam logic [4:0] MAIN_LIMIT_RST = 5'd16;
   localparam logic [3:0] IN_LIMIT_RST   = 4'd8;
   localparam logic [3:0] OUT_LIMIT_RST  = 4'd8;

   localparam logic [1:0] CSR_MAIN_LIMIT = 2'd0;
   localparam logic [1:0] CSR_IN_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_OUT_LIMIT  = 2'd2;

   localparam logic [1:0] CLS_MISS = 2'd0;
   localparam logic [1:0] CLS_MAIN = 2'd1;
   localparam logic [1:0] CLS_IN   = 2'd2;
   localparam logic [1:0] CLS_OUT  = 2'd3;

   localparam logic [31:0] MISS_DATA = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      Q_MAIN,
      Q_IN,
      Q_OUT
   } queue_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRD,
      ST_SCMP,
      ST_PCHK,
      ST_PDISP,
      ST_URD,
      ST_UWR,
      ST_DRD,
      ST_DWR
   } state_type;

endpackage

// ===== rtl/core/two_queue_cache_policy.sv =====
// 2Q cache policy: three queues in one entry memory, walked by a sequencer.
// Entries are searched one by one (main, then input, then out queue), and on a
// hit or insert, entries are moved to reorder the queue; one access at a time,
// start is taken only when idle. One result beat per access; the receiver cannot stall.
// Reset (synchronous): queues empty, limits 16/8/8; memory is not cleared.
module two_queue_cache_policy
   import tqc_pkg::*;
#(
   parameter int MAIN_DEPTH = MAIN_DEPTH_DEF,
   parameter int IN_DEPTH   = IN_DEPTH_DEF,
   parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_page_number,
   input  logic signed [31:0] req_fill_data,
   output logic               rsp_valid,
   output logic [1:0]         rsp_hit_class,
   output logic signed [31:0] rsp_read_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata
);

   localparam int TOTAL = MAIN_DEPTH + IN_DEPTH + OUT_DEPTH;
   localparam int AW    = $clog2(TOTAL);
   localparam int MAXD  = (MAIN_DEPTH > IN_DEPTH) ?
                          ((MAIN_DEPTH > OUT_DEPTH) ? MAIN_DEPTH : OUT_DEPTH) :
                          ((IN_DEPTH > OUT_DEPTH) ? IN_DEPTH : OUT_DEPTH);
   localparam int IW    = $clog2(MAXD + 1);

   localparam logic [AW-1:0] BASE_MAIN = '0;
   localparam logic [AW-1:0] BASE_IN   = AW'(MAIN_DEPTH);
   localparam logic [AW-1:0] BASE_OUT  = AW'(MAIN_DEPTH + IN_DEPTH);

   function automatic logic [IW-1:0] clamp(input logic [4:0] raw, input int depth);
      int r;
      r = int'(raw);
      if (r < 1) r = 1;
      if (r > depth) r = depth;
      return IW'(r);
   endfunction

   logic [63:0] mem [TOTAL];
   logic [63:0] rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   queue_type q_ff, q_in;
   logic [IW-1:0] j_ff, j_in;
   logic [31:0] page_ff, page_in, fill_ff, fill_in;
   logic [63:0] ent_ff, ent_in, dsp_ff, dsp_in;
   logic disp_ff, disp_in, mv_ff, mv_in;
   logic [1:0] cls_ff, cls_in;
   logic [31:0] rdat_ff, rdat_in;
   logic [IW-1:0] mcnt_ff, mcnt_in, icnt_ff, icnt_in, ocnt_ff, ocnt_in;
   logic [4:0] mlim_ff, mlim_in;
   logic [3:0] ilim_ff, ilim_in, olim_ff, olim_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_cls_ff, rsp_cls_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [IW-1:0] mlim, ilim, olim, cnt_sel, lim_sel, cnt_new;
   logic [AW-1:0] base_sel;
   logic cnt_we;

   assign mlim = clamp(mlim_ff, MAIN_DEPTH);
   assign ilim = clamp({1'b0, ilim_ff}, IN_DEPTH);
   assign olim = clamp({1'b0, olim_ff}, OUT_DEPTH);

   always_comb begin
      case (q_ff)
         Q_MAIN: begin
            cnt_sel = mcnt_ff; lim_sel = mlim; base_sel = BASE_MAIN;
         end
         Q_IN: begin
            cnt_sel = icnt_ff; lim_sel = ilim; base_sel = BASE_IN;
         end
         default: begin
            cnt_sel = ocnt_ff; lim_sel = olim; base_sel = BASE_OUT;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff; q_in = q_ff; j_in = j_ff;
      page_in = page_ff; fill_in = fill_ff; ent_in = ent_ff; dsp_in = dsp_ff;
      disp_in = disp_ff; mv_in = mv_ff; cls_in = cls_ff; rdat_in = rdat_ff;
      rsp_valid_in = 1'b0; rsp_cls_in = rsp_cls_ff; rsp_data_in = rsp_data_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_waddr = '0; mem_raddr = '0; mem_wdata = ent_ff;
      cnt_we = 1'b0; cnt_new = cnt_sel;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               page_in = req_page_number; fill_in = req_fill_data;
               q_in = Q_MAIN; j_in = '0; disp_in = 1'b0;
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            if (j_ff < cnt_sel) begin
               mem_re = 1'b1; mem_raddr = base_sel + AW'(j_ff);
               state_in = ST_SCMP;
            end else if (q_ff == Q_MAIN) begin
               q_in = Q_IN; j_in = '0;
            end else if (q_ff == Q_IN) begin
               q_in = Q_OUT; j_in = '0;
            end else begin
               ent_in = {page_ff, fill_ff}; cls_in = CLS_MISS; rdat_in = MISS_DATA;
               q_in = Q_IN; mv_in = 1'b0; state_in = ST_PCHK;
            end
         end
         ST_SCMP: begin
            if (rd_ff[63:32] == page_ff) begin
               ent_in = rd_ff; rdat_in = rd_ff[31:0];
               case (q_ff)
                  Q_MAIN: begin cls_in = CLS_MAIN; mv_in = 1'b1; state_in = ST_URD; end
                  Q_IN:   begin cls_in = CLS_IN;   mv_in = 1'b1; state_in = ST_URD; end
                  default: begin cls_in = CLS_OUT; state_in = ST_DRD; end
               endcase
            end else begin
               j_in = IW'(j_ff + 1'b1); state_in = ST_SRD;
            end
         end
         ST_DRD: begin
            if (IW'(j_ff + 1'b1) < ocnt_ff) begin
               mem_re = 1'b1; mem_raddr = BASE_OUT + AW'(j_ff) + AW'(1);
               state_in = ST_DWR;
            end else begin
               cnt_we = 1'b1; cnt_new = IW'(ocnt_ff - 1'b1);
               q_in = Q_MAIN; mv_in = 1'b0; state_in = ST_PCHK;
            end
         end
         ST_DWR: begin
            mem_we = 1'b1; mem_waddr = BASE_OUT + AW'(j_ff); mem_wdata = rd_ff;
            j_in = IW'(j_ff + 1'b1); state_in = ST_DRD;
         end
         ST_PCHK: begin
            if (cnt_sel >= lim_sel) begin
               cnt_we = 1'b1; cnt_new = IW'(lim_sel - 1'b1); j_in = cnt_new;
               if (q_ff == Q_IN) begin
                  mem_re = 1'b1; mem_raddr = base_sel + AW'(cnt_new);
                  state_in = ST_PDISP;
               end else begin
                  state_in = ST_URD;
               end
            end else begin
               j_in = cnt_sel; state_in = ST_URD;
            end
         end
         ST_PDISP: begin
            dsp_in = rd_ff; disp_in = 1'b1; state_in = ST_URD;
         end
         ST_URD: begin
            if (j_ff == '0) begin
               mem_we = 1'b1; mem_waddr = base_sel; mem_wdata = ent_ff;
               if (!mv_ff) begin
                  cnt_we = 1'b1; cnt_new = IW'(cnt_sel + 1'b1);
               end
               if (disp_ff) begin
                  q_in = Q_OUT; ent_in = dsp_ff; disp_in = 1'b0; mv_in = 1'b0;
                  state_in = ST_PCHK;
               end else begin
                  rsp_valid_in = 1'b1; rsp_cls_in = cls_ff; rsp_data_in = rdat_ff;
                  state_in = ST_IDLE;
               end
            end else begin
               mem_re = 1'b1; mem_raddr = base_sel + AW'(j_ff) - AW'(1);
               state_in = ST_UWR;
            end
         end
         ST_UWR: begin
            mem_we = 1'b1; mem_waddr = base_sel + AW'(j_ff); mem_wdata = rd_ff;
            j_in = IW'(j_ff - 1'b1); state_in = ST_URD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mcnt_in = mcnt_ff; icnt_in = icnt_ff; ocnt_in = ocnt_ff;
      mlim_in = mlim_ff; ilim_in = ilim_ff; olim_in = olim_ff;
      if (cnt_we) begin
         case (q_ff)
            Q_MAIN:  mcnt_in = cnt_new;
            Q_IN:    icnt_in = cnt_new;
            default: ocnt_in = cnt_new;
         endcase
      end
      if (csr_we) begin
         case (csr_index)
            CSR_MAIN_LIMIT: begin
               mlim_in = csr_wdata;
               if (mcnt_ff > clamp(csr_wdata, MAIN_DEPTH))
                  mcnt_in = clamp(csr_wdata, MAIN_DEPTH);
            end
            CSR_IN_LIMIT: begin
               ilim_in = csr_wdata[3:0];
               if (icnt_ff > clamp({1'b0, csr_wdata[3:0]}, IN_DEPTH))
                  icnt_in = clamp({1'b0, csr_wdata[3:0]}, IN_DEPTH);
            end
            CSR_OUT_LIMIT: begin
               olim_in = csr_wdata[3:0];
               if (ocnt_ff > clamp({1'b0, csr_wdata[3:0]}, OUT_DEPTH))
                  ocnt_in = clamp({1'b0, csr_wdata[3:0]}, OUT_DEPTH);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mcnt_ff <= '0; icnt_ff <= '0; ocnt_ff <= '0;
         mlim_ff <= MAIN_LIMIT_RST; ilim_ff <= IN_LIMIT_RST; olim_ff <= OUT_LIMIT_RST;
         disp_ff <= 1'b0; mv_ff <= 1'b0;
         q_ff <= Q_MAIN;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff <= mcnt_in; icnt_ff <= icnt_in; ocnt_ff <= ocnt_in;
         mlim_ff <= mlim_in; ilim_ff <= ilim_in; olim_ff <= olim_in;
         disp_ff <= disp_in; mv_ff <= mv_in;
         q_ff <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in; page_ff <= page_in; fill_ff <= fill_in;
      ent_ff <= ent_in; dsp_ff <= dsp_in; cls_ff <= cls_in; rdat_ff <= rdat_in;
      rsp_cls_ff <= rsp_cls_in; rsp_data_ff <= rsp_data_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit_class = rsp_cls_ff;
   assign rsp_read_data = rsp_data_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted beat did not start work");
   a_miss_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_class == CLS_MISS |-> rsp_read_data == MISS_DATA)
      else $error("miss without all-ones data");
   a_cnt_lim: assert property (@(posedge clock) disable iff (reset)
      mcnt_ff <= mlim && icnt_ff <= ilim && ocnt_ff <= olim)
      else $error("queue count above limit");

endmodule
